FILE: rtl/core/indexed_min_heap_decrement_assert.svh
// Assertion macros for the indexed min-heap RTL.
// Depends on nothing; included by indexed_min_heap_decrement.sv for its concurrent checks.
`ifndef INDEXED_MIN_HEAP_DECREMENT_ASSERT_SVH
`define INDEXED_MIN_HEAP_DECREMENT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IMHD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define IMHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/imhd_pkg.sv
// Package for the indexed min-heap: beat types, request and status codes, states.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package imhd_pkg;

   localparam int KEY_BITS  = 10;
   localparam int KEY_SPACE = 1024;

   localparam logic [1:0] REQ_INSERT    = 2'd0;
   localparam logic [1:0] REQ_DECREMENT = 2'd1;
   localparam logic [1:0] REQ_POP       = 2'd2;
   localparam logic [1:0] REQ_SPARE     = 2'd3;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_EMPTY   = 3'd1;
   localparam logic [2:0] STATUS_FULL    = 3'd2;
   localparam logic [2:0] STATUS_PRESENT = 3'd3;
   localparam logic [2:0] STATUS_ABSENT  = 3'd4;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [KEY_BITS-1:0] key;
      logic [31:0]         value;
   } req_payload_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] out_key;
      logic [31:0]         out_value;
      logic [2:0]          status;
      logic [10:0]         entry_count;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_CHECK,
      ST_DEC,
      ST_UP,
      ST_UP_CMP,
      ST_DOWN,
      ST_DN_CMP,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/indexed_min_heap_decrement.sv
// Indexed binary min-heap with insert, decrement-by-one and pop-min.
// Depends on imhd_pkg and indexed_min_heap_decrement_assert.svh.
//
// Usage: one request beat on req_* (valid/stall) gives exactly one result
// beat on rsp_*. Insert places a key/value and sifts it up; decrement lowers
// a present key's value by one (saturating at zero) and sifts it up; pop
// returns the root and sifts the last entry down from the root.
// The heap lives in a two-read, one-write slot memory and the key-to-slot map
// in a one-read, one-write memory, both with registered reads.
// One item is worked at a time. The result is registered and becomes valid as
// the block returns to idle, where the next request can be taken.
// After reset the key map is swept clear, one entry a cycle, over all 1024
// entries while req_stall is high; the heap then starts empty.
// Results wait in an output register: while rsp_stall is held the beat stays
// unchanged, and the block still accepts and works the next request, holding
// its result until the register is free.
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_min_heap_decrement_assert.svh"

module indexed_min_heap_decrement #(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  imhd_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output imhd_pkg::rsp_payload_type rsp_data
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int NW = $clog2(CAPACITY + 1);
   localparam int CW = IW + 2;
   localparam int KB = imhd_pkg::KEY_BITS;
   localparam int KS = imhd_pkg::KEY_SPACE;

   // Memories: heap slots and key-to-slot map (present bit on top).
   logic [KB-1:0]         heap_key_mem [CAPACITY];
   logic [VALUE_BITS-1:0] heap_val_mem [CAPACITY];
   logic [IW:0]           slot_mem     [KS];

   logic [KB-1:0]         ha_key_q, hb_key_q;
   logic [VALUE_BITS-1:0] ha_val_q, hb_val_q;
   logic [IW:0]           pm_q;

   logic [IW-1:0]         ha_addr, hb_addr, hw_addr;
   logic                  hw_en;
   logic [KB-1:0]         hw_key;
   logic [VALUE_BITS-1:0] hw_val;
   logic [KB-1:0]         pr_addr, pw_addr;
   logic                  pw_en;
   logic [IW:0]           pw_data;

   // Control and work registers.
   imhd_pkg::state_type   state_ff, state_in;
   logic [KB-1:0]         clr_ff, clr_in;
   logic [NW-1:0]         fill_ff, fill_in;
   logic [IW-1:0]         hole_ff, hole_in;
   logic [KB-1:0]         item_key_ff, item_key_in;
   logic [VALUE_BITS-1:0] item_val_ff, item_val_in;
   logic [1:0]            op_ff, op_in;
   logic [KB-1:0]         key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [KB-1:0]         okey_ff, okey_in;
   logic [VALUE_BITS-1:0] oval_ff, oval_in;
   logic [2:0]            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   imhd_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // Index arithmetic.
   logic [IW-1:0]         par, gpar;
   logic [CW-1:0]         lft, rgt, fill_c, nl;
   logic                  take_r;
   logic [KB-1:0]         pick_key;
   logic [VALUE_BITS-1:0] pick_val;
   logic [IW-1:0]         pick_idx;
   logic                  present;
   logic [IW-1:0]         slot;

   assign par    = (hole_ff - IW'(1)) >> 1;
   assign gpar   = (par - IW'(1)) >> 1;
   assign lft    = (CW'(hole_ff) << 1) + CW'(1);
   assign rgt    = lft + CW'(1);
   assign fill_c = CW'(fill_ff);
   assign take_r = (rgt < fill_c) && (hb_val_q < ha_val_q);
   assign pick_key = take_r ? hb_key_q : ha_key_q;
   assign pick_val = take_r ? hb_val_q : ha_val_q;
   assign pick_idx = take_r ? rgt[IW-1:0] : lft[IW-1:0];
   assign nl       = (CW'(pick_idx) << 1) + CW'(1);
   assign present  = pm_q[IW];
   assign slot     = pm_q[IW-1:0];

   assign req_stall = (state_ff != imhd_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Heap slot memory: one write, two registered reads.
   always_ff @(posedge clock) begin
      if (hw_en) begin
         heap_key_mem[hw_addr] <= hw_key;
         heap_val_mem[hw_addr] <= hw_val;
      end
      ha_key_q <= heap_key_mem[ha_addr];
      ha_val_q <= heap_val_mem[ha_addr];
      hb_key_q <= heap_key_mem[hb_addr];
      hb_val_q <= heap_val_mem[hb_addr];
   end

   // Key-to-slot map memory: one write, one registered read.
   always_ff @(posedge clock) begin
      if (pw_en) begin
         slot_mem[pw_addr] <= pw_data;
      end
      pm_q <= slot_mem[pr_addr];
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imhd_pkg::ST_CLEAR;
         clr_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hole_ff     <= hole_in;
      item_key_ff <= item_key_in;
      item_val_ff <= item_val_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      okey_ff     <= okey_in;
      oval_ff     <= oval_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sequencer: next state, memory accesses and work registers.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      fill_in      = fill_ff;
      hole_in      = hole_ff;
      item_key_in  = item_key_ff;
      item_val_in  = item_val_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      okey_in      = okey_ff;
      oval_in      = oval_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ha_addr      = '0;
      hb_addr      = '0;
      hw_en        = 1'b0;
      hw_addr      = hole_ff;
      hw_key       = item_key_ff;
      hw_val       = item_val_ff;
      pr_addr      = key_ff;
      pw_en        = 1'b0;
      pw_addr      = item_key_ff;
      pw_data      = {1'b1, hole_ff};

      case (state_ff)
         imhd_pkg::ST_CLEAR: begin
            pw_en   = 1'b1;
            pw_addr = clr_ff;
            pw_data = '0;
            clr_in  = clr_ff + KB'(1);
            if (clr_ff == KB'(KS - 1)) begin
               state_in = imhd_pkg::ST_IDLE;
            end
         end
         imhd_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.req_type;
               key_in    = req_data.key;
               val_in    = VALUE_BITS'(req_data.value);
               okey_in   = '0;
               oval_in   = '0;
               status_in = imhd_pkg::STATUS_OK;
               state_in  = imhd_pkg::ST_LOOK;
            end
         end
         imhd_pkg::ST_LOOK: begin
            // Fetch the key's map entry, the root and the last slot.
            pr_addr  = key_ff;
            ha_addr  = '0;
            hb_addr  = IW'(fill_ff - NW'(1));
            state_in = imhd_pkg::ST_CHECK;
         end
         imhd_pkg::ST_CHECK: begin
            case (op_ff)
               imhd_pkg::REQ_INSERT: begin
                  if (fill_ff >= NW'(CAPACITY)) begin
                     status_in = imhd_pkg::STATUS_FULL;
                     state_in  = imhd_pkg::ST_RESP;
                  end else if (present) begin
                     status_in = imhd_pkg::STATUS_PRESENT;
                     state_in  = imhd_pkg::ST_RESP;
                  end else begin
                     item_key_in = key_ff;
                     item_val_in = val_ff;
                     hole_in     = IW'(fill_ff);
                     fill_in     = fill_ff + NW'(1);
                     state_in    = imhd_pkg::ST_UP;
                  end
               end
               imhd_pkg::REQ_DECREMENT: begin
                  if (!present || (NW'(slot) >= fill_ff)) begin
                     status_in = imhd_pkg::STATUS_ABSENT;
                     state_in  = imhd_pkg::ST_RESP;
                  end else begin
                     ha_addr  = slot;
                     hole_in  = slot;
                     state_in = imhd_pkg::ST_DEC;
                  end
               end
               imhd_pkg::REQ_POP: begin
                  if (fill_ff == '0) begin
                     status_in = imhd_pkg::STATUS_EMPTY;
                     state_in  = imhd_pkg::ST_RESP;
                  end else begin
                     okey_in = ha_key_q;
                     oval_in = ha_val_q;
                     pw_en   = 1'b1;
                     pw_addr = ha_key_q;
                     pw_data = '0;
                     fill_in = fill_ff - NW'(1);
                     if (fill_ff == NW'(1)) begin
                        state_in = imhd_pkg::ST_RESP;
                     end else begin
                        item_key_in = hb_key_q;
                        item_val_in = hb_val_q;
                        hole_in     = '0;
                        state_in    = imhd_pkg::ST_DOWN;
                     end
                  end
               end
               default: begin
                  state_in = imhd_pkg::ST_RESP;
               end
            endcase
         end
         imhd_pkg::ST_DEC: begin
            // Saturating decrement of the entry's value.
            item_key_in = key_ff;
            if (ha_val_q == '0) begin
               item_val_in = '0;
               oval_in     = '0;
            end else begin
               item_val_in = ha_val_q - VALUE_BITS'(1);
               oval_in     = ha_val_q - VALUE_BITS'(1);
            end
            state_in = imhd_pkg::ST_UP;
         end
         imhd_pkg::ST_UP: begin
            if (hole_ff == '0) begin
               hw_en    = 1'b1;
               pw_en    = 1'b1;
               state_in = imhd_pkg::ST_RESP;
            end else begin
               ha_addr  = par;
               state_in = imhd_pkg::ST_UP_CMP;
            end
         end
         imhd_pkg::ST_UP_CMP: begin
            // Parent moves down into the hole while it is strictly greater.
            if (ha_val_q > item_val_ff) begin
               hw_en   = 1'b1;
               hw_key  = ha_key_q;
               hw_val  = ha_val_q;
               pw_en   = 1'b1;
               pw_addr = ha_key_q;
               hole_in = par;
               if (par == '0) begin
                  state_in = imhd_pkg::ST_UP;
               end else begin
                  ha_addr = gpar;
               end
            end else begin
               hw_en    = 1'b1;
               pw_en    = 1'b1;
               state_in = imhd_pkg::ST_RESP;
            end
         end
         imhd_pkg::ST_DOWN: begin
            if (lft >= fill_c) begin
               hw_en    = 1'b1;
               pw_en    = 1'b1;
               state_in = imhd_pkg::ST_RESP;
            end else begin
               ha_addr  = lft[IW-1:0];
               hb_addr  = rgt[IW-1:0];
               state_in = imhd_pkg::ST_DN_CMP;
            end
         end
         imhd_pkg::ST_DN_CMP: begin
            // Smaller child (left on ties) moves up while strictly smaller.
            if (pick_val < item_val_ff) begin
               hw_en   = 1'b1;
               hw_key  = pick_key;
               hw_val  = pick_val;
               pw_en   = 1'b1;
               pw_addr = pick_key;
               hole_in = pick_idx;
               if (nl < fill_c) begin
                  ha_addr = nl[IW-1:0];
                  hb_addr = IW'(nl + CW'(1));
               end else begin
                  state_in = imhd_pkg::ST_DOWN;
               end
            end else begin
               hw_en    = 1'b1;
               pw_en    = 1'b1;
               state_in = imhd_pkg::ST_RESP;
            end
         end
         imhd_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_key     = okey_ff;
               rsp_data_in.out_value   = 32'(oval_ff);
               rsp_data_in.status      = status_ff;
               rsp_data_in.entry_count = 11'(fill_ff);
               state_in                = imhd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = imhd_pkg::ST_IDLE;
         end
      endcase
   end

   // Checks on the sequencer.
   `IMHD_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= NW'(CAPACITY), "fill over capacity")
   `IMHD_ASSERT_NOW(a_clear_stalls, clock, reset, state_ff == imhd_pkg::ST_CLEAR, req_stall, "request taken during clear")
   `IMHD_ASSERT_NOW(a_up_hole, clock, reset, state_ff == imhd_pkg::ST_UP_CMP, hole_ff != '0, "sift-up compare at root")
   `IMHD_ASSERT_NEXT(a_full_status, clock, reset, (state_ff == imhd_pkg::ST_RESP) && (status_ff == imhd_pkg::STATUS_FULL) && (!rsp_valid_ff || !rsp_stall), rsp_data_ff.entry_count == 11'(CAPACITY), "full status with room left")

endmodule

`default_nettype wire
